### src/shmc_pkg.sv
// Shared types and constants for the stepper home-and-move controller.
// Holds the transfer payload structs, the configuration struct, and the codes.
// No dependencies.
package shmc_pkg;

  // Default widths of the position counter and the phase timer.
  localparam int unsigned PositionBitsDef = 24;
  localparam int unsigned TimerBitsDef    = 20;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PULSE_HIGH   = 3'd0,
    CFG_HOME_LOW     = 3'd1,
    CFG_RUN_LOW      = 3'd2,
    CFG_CLEAR_WINDOW = 3'd3,
    CFG_ACTIVE_LOW   = 3'd4,
    CFG_HOME_FWD     = 3'd5
  } cfg_idx_e;

  // Command codes carried in the action field.
  localparam logic [1:0] ActTick = 2'd0;
  localparam logic [1:0] ActHome = 2'd1;
  localparam logic [1:0] ActMove = 2'd2;

  // Controller mode, one-hot.
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_HOMING = 4'b0010,
    MODE_MOVING = 4'b0100,
    MODE_FAULT  = 4'b1000
  } mode_e;

  // Configuration registers.
  typedef struct packed {
    logic [7:0]  pulse_high_ticks;
    logic [19:0] home_low_ticks;
    logic [19:0] run_low_ticks;
    logic [15:0] clear_window_steps;
    logic        endstop_invert;
    logic        home_forward;
  } cfg_t;

  // Reset values of the configuration registers.
  localparam cfg_t CfgReset = '{
    pulse_high_ticks:   8'd5,
    home_low_ticks:     20'd1495,
    run_low_ticks:      20'd245,
    clear_window_steps: 16'd222,
    endstop_invert:     1'b0,
    home_forward:       1'b0
  };

  // One input tick.
  typedef struct packed {
    logic [1:0]         action;
    logic signed [23:0] target_position;
    logic               endstop_level;
  } in_t;

  // One result per tick.
  typedef struct packed {
    logic               step_out;
    logic               dir_out;
    logic               driver_disable;
    logic               busy_res;
    logic               fault;
    logic signed [23:0] position;
  } out_t;

endpackage

### src/stepper_home_and_move_controller.sv
// Top level of the step/direction stepper controller with homing and fault check.
// Holds the input register, controller state, configuration and result register.
// Depends on shmc_pkg and shmc_step.
//
//   channel   signals                          direction  moves per transfer
//   input     in_valid_i, in_stall_o, in_data_i   in      one tick (in_t)
//   output    out_valid_o, out_stall_i, out_data_o out    one result (out_t)
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i    in      one register write
//
// One tick is accepted per cycle while in_stall_o is low; the tick is held in the input
// register, and its result then in the output register, before it reaches the output.
// The tick is first registered, then the state update and result are computed in
// one pass and loaded into the output register together.
// Reset clears the state and loads the configuration defaults; no clearing pass.
// A stall on the output holds the result register, then the input register.
module stepper_home_and_move_controller #(
  parameter int unsigned POSITION_BITS = shmc_pkg::PositionBitsDef,
  parameter int unsigned TIMER_BITS    = shmc_pkg::TimerBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  shmc_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output shmc_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [shmc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [shmc_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  shmc_pkg::cfg_t           cfg_q;
  logic                     s1_valid_q;
  shmc_pkg::in_t            s1_item_q;
  logic                     out_valid_q;
  shmc_pkg::out_t           out_data_q;
  logic                     out_ready;
  logic                     in_ready;
  logic                     adv;

  shmc_pkg::mode_e          mode_q, mode_d;
  logic                     high_q, high_d;
  logic [TIMER_BITS-1:0]    timer_q, timer_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] tgt_q, tgt_d;
  logic                     dir_q, dir_d;
  logic                     armed_q, armed_d;
  logic [15:0]              dl_q, dl_d;
  shmc_pkg::out_t           res;

  // Handshake: the output register frees up when empty or taken this cycle.
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign in_ready    = !s1_valid_q || out_ready;
  assign adv         = s1_valid_q && out_ready;
  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= shmc_pkg::CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        shmc_pkg::CFG_PULSE_HIGH:   cfg_q.pulse_high_ticks   <= cfg_wdata_i[7:0];
        shmc_pkg::CFG_HOME_LOW:     cfg_q.home_low_ticks     <= cfg_wdata_i[19:0];
        shmc_pkg::CFG_RUN_LOW:      cfg_q.run_low_ticks      <= cfg_wdata_i[19:0];
        shmc_pkg::CFG_CLEAR_WINDOW: cfg_q.clear_window_steps <= cfg_wdata_i[15:0];
        shmc_pkg::CFG_ACTIVE_LOW:   cfg_q.endstop_invert     <= cfg_wdata_i[0];
        shmc_pkg::CFG_HOME_FWD:     cfg_q.home_forward       <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Input register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
  end

  // Per-tick state update.
  shmc_step #(
    .POSITION_BITS(POSITION_BITS),
    .TIMER_BITS   (TIMER_BITS)
  ) u_step (
    .cfg_i     (cfg_q),
    .item_i    (s1_item_q),
    .mode_i    (mode_q),
    .high_i    (high_q),
    .timer_i   (timer_q),
    .pos_i     (pos_q),
    .tgt_i     (tgt_q),
    .dir_i     (dir_q),
    .armed_i   (armed_q),
    .deadline_i(dl_q),
    .mode_o    (mode_d),
    .high_o    (high_d),
    .timer_o   (timer_d),
    .pos_o     (pos_d),
    .tgt_o     (tgt_d),
    .dir_o     (dir_d),
    .armed_o   (armed_d),
    .deadline_o(dl_d),
    .res_o     (res)
  );

  // Controller state advances once per tick moved into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= shmc_pkg::MODE_IDLE;
      high_q  <= 1'b0;
      timer_q <= '0;
      pos_q   <= '0;
      tgt_q   <= '0;
      dir_q   <= 1'b0;
      armed_q <= 1'b0;
      dl_q    <= '0;
    end else if (adv) begin
      mode_q  <= mode_d;
      high_q  <= high_d;
      timer_q <= timer_d;
      pos_q   <= pos_d;
      tgt_q   <= tgt_d;
      dir_q   <= dir_d;
      armed_q <= armed_d;
      dl_q    <= dl_d;
    end
  end

  // Output register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= res;
    end
  end

endmodule

### src/shmc_step.sv
// Next-state and result logic for one tick of the stepper controller.
// Purely combinational; the top level holds all registers.
// Depends on shmc_pkg.
module shmc_step #(
  parameter int unsigned POSITION_BITS = shmc_pkg::PositionBitsDef,
  parameter int unsigned TIMER_BITS    = shmc_pkg::TimerBitsDef
) (
  input  shmc_pkg::cfg_t           cfg_i,
  input  shmc_pkg::in_t            item_i,
  input  shmc_pkg::mode_e          mode_i,
  input  logic                     high_i,
  input  logic [TIMER_BITS-1:0]    timer_i,
  input  logic [POSITION_BITS-1:0] pos_i,
  input  logic [POSITION_BITS-1:0] tgt_i,
  input  logic                     dir_i,
  input  logic                     armed_i,
  input  logic [15:0]              deadline_i,
  output shmc_pkg::mode_e          mode_o,
  output logic                     high_o,
  output logic [TIMER_BITS-1:0]    timer_o,
  output logic [POSITION_BITS-1:0] pos_o,
  output logic [POSITION_BITS-1:0] tgt_o,
  output logic                     dir_o,
  output logic                     armed_o,
  output logic [15:0]              deadline_o,
  output shmc_pkg::out_t           res_o
);

  localparam int unsigned CmpW = POSITION_BITS + 17;

  logic                        active;
  logic [POSITION_BITS-1:0]    cmd_tgt;
  logic [TIMER_BITS-1:0]       high_lim;
  logic [TIMER_BITS-1:0]       low_lim;
  logic [POSITION_BITS-1:0]    pos_step;
  logic signed [CmpW-1:0]      pos_ext;
  logic signed [CmpW-1:0]      dl_ext;
  logic                        past_deadline;
  logic                        bnd;
  shmc_pkg::mode_e             mode_m;

  // Endstop polarity, command target at position width, and phase limits.
  assign active   = item_i.endstop_level ^ cfg_i.endstop_invert;
  assign cmd_tgt  = POSITION_BITS'(item_i.target_position);
  assign high_lim = TIMER_BITS'(cfg_i.pulse_high_ticks);
  assign low_lim  = (mode_i == shmc_pkg::MODE_HOMING) ? TIMER_BITS'(cfg_i.home_low_ticks)
                                                      : TIMER_BITS'(cfg_i.run_low_ticks);

  // Position after one step, and the signed compare against the clear window.
  assign pos_step      = pos_i + (dir_i ? POSITION_BITS'(1) : {POSITION_BITS{1'b1}});
  assign pos_ext       = CmpW'($signed(pos_step));
  assign dl_ext        = CmpW'(deadline_i);
  assign past_deadline = (pos_ext >= dl_ext);

  // Tick update: command start or pulse timing, then the step-boundary decision.
  always_comb begin
    mode_m     = mode_i;
    high_o     = high_i;
    timer_o    = timer_i;
    pos_o      = pos_i;
    tgt_o      = tgt_i;
    dir_o      = dir_i;
    armed_o    = armed_i;
    deadline_o = deadline_i;
    bnd        = 1'b0;

    unique case (mode_i)
      shmc_pkg::MODE_IDLE: begin
        if (item_i.action == shmc_pkg::ActHome) begin
          mode_m  = shmc_pkg::MODE_HOMING;
          dir_o   = cfg_i.home_forward;
          armed_o = 1'b0;
          bnd     = 1'b1;
        end else if (item_i.action == shmc_pkg::ActMove) begin
          tgt_o = cmd_tgt;
          if (cmd_tgt != pos_i) begin
            dir_o      = $signed(cmd_tgt) > $signed(pos_i);
            armed_o    = ($signed(cmd_tgt) > $signed(pos_i)) && (pos_i == '0) && active;
            deadline_o = cfg_i.clear_window_steps;
            mode_m     = shmc_pkg::MODE_MOVING;
            bnd        = 1'b1;
          end
        end
      end
      shmc_pkg::MODE_HOMING, shmc_pkg::MODE_MOVING: begin
        if (high_i) begin
          if (timer_i >= high_lim) begin
            high_o  = 1'b0;
            timer_o = TIMER_BITS'(1);
          end else begin
            timer_o = timer_i + TIMER_BITS'(1);
          end
        end else if (timer_i >= low_lim) begin
          pos_o   = pos_step;
          timer_o = '0;
          if ((mode_i == shmc_pkg::MODE_MOVING) && armed_i) begin
            if (!active) begin
              armed_o = 1'b0;
            end else if (past_deadline) begin
              mode_m  = shmc_pkg::MODE_FAULT;
              armed_o = 1'b0;
            end
          end
          bnd = (mode_m != shmc_pkg::MODE_FAULT);
        end else begin
          timer_o = timer_i + TIMER_BITS'(1);
        end
      end
      default: begin
        // Fault holds everything until reset.
      end
    endcase

    // Step boundary: finish the operation or start the next pulse.
    mode_o = mode_m;
    if (bnd) begin
      if (mode_m == shmc_pkg::MODE_HOMING) begin
        if (active) begin
          pos_o  = '0;
          mode_o = shmc_pkg::MODE_IDLE;
        end else begin
          high_o  = 1'b1;
          timer_o = TIMER_BITS'(1);
        end
      end else if (mode_m == shmc_pkg::MODE_MOVING) begin
        if (pos_o == tgt_o) begin
          mode_o  = shmc_pkg::MODE_IDLE;
          armed_o = 1'b0;
        end else begin
          high_o  = 1'b1;
          timer_o = TIMER_BITS'(1);
        end
      end
    end
  end

  // Result fields from the updated state.
  always_comb begin
    res_o.step_out       = high_o;
    res_o.dir_out        = dir_o;
    res_o.driver_disable = (mode_o == shmc_pkg::MODE_FAULT);
    res_o.busy_res       = (mode_o == shmc_pkg::MODE_HOMING) ||
                           (mode_o == shmc_pkg::MODE_MOVING);
    res_o.fault          = (mode_o == shmc_pkg::MODE_FAULT);
    res_o.position       = 24'($signed(pos_o));
  end

endmodule

### bench/shmc_tb_pkg.sv
// Scoreboard for the stepper home-and-move controller testbench.
// Predicts the line levels and position for every accepted tick and checks results.
// Depends on shmc_pkg.
`timescale 1ns / 1ps

package shmc_tb_pkg;
  import shmc_pkg::*;

  // The action field has one code with no meaning; the block ignores it.
  localparam logic [1:0] ActUnused = 2'd3;

  class motion_scoreboard;
    // Register copy and controller state, tracked tick by tick.
    cfg_t               cfg;
    mode_e              mode;
    logic               high_phase;
    logic [19:0]        phase_tmr;
    logic signed [23:0] pos;
    logic signed [23:0] target;
    logic               dir;
    logic               armed;
    logic [15:0]        deadline;

    // Expected results in the order the ticks were accepted.
    out_t        expected_lines[$];
    int unsigned mismatches;
    int unsigned ticks;
    int unsigned checked;
    int unsigned homes;
    int unsigned moves;

    function new();
      cfg        = CfgReset;
      mode       = MODE_IDLE;
      high_phase = 1'b0;
      phase_tmr  = '0;
      pos        = '0;
      target     = '0;
      dir        = 1'b0;
      armed      = 1'b0;
      deadline   = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [19:0] v);
      case (idx)
        CFG_PULSE_HIGH:   cfg.pulse_high_ticks   = v[7:0];
        CFG_HOME_LOW:     cfg.home_low_ticks     = v;
        CFG_RUN_LOW:      cfg.run_low_ticks      = v;
        CFG_CLEAR_WINDOW: cfg.clear_window_steps = v[15:0];
        CFG_ACTIVE_LOW:   cfg.endstop_invert     = v[0];
        CFG_HOME_FWD:     cfg.home_forward       = v[0];
        default: ;
      endcase
    endfunction

    // At a step boundary the controller either finishes or starts the next pulse.
    function void step_boundary(logic active);
      if (mode == MODE_HOMING) begin
        if (active) begin
          pos  = '0;
          mode = MODE_IDLE;
          return;
        end
      end else if (mode == MODE_MOVING) begin
        if (pos == target) begin
          mode  = MODE_IDLE;
          armed = 1'b0;
          return;
        end
      end else begin
        return;
      end
      high_phase = 1'b1;
      phase_tmr  = 20'd1;
    endfunction

    function void note_tick(in_t it);
      logic  active;
      logic [19:0] low_ticks;
      out_t  e;
      active = it.endstop_level ^ cfg.endstop_invert;
      ticks++;
      if (mode == MODE_IDLE) begin
        if (it.action == ActHome) begin
          homes++;
          mode  = MODE_HOMING;
          dir   = cfg.home_forward;
          armed = 1'b0;
          step_boundary(active);
        end else if (it.action == ActMove) begin
          target = it.target_position;
          if (target != pos) begin
            moves++;
            dir      = target > pos;
            armed    = dir && pos == 0 && active;
            deadline = cfg.clear_window_steps;
            mode     = MODE_MOVING;
            step_boundary(active);
          end
        end
      end else if (mode == MODE_HOMING || mode == MODE_MOVING) begin
        if (high_phase) begin
          if (phase_tmr >= 20'(cfg.pulse_high_ticks)) begin
            high_phase = 1'b0;
            phase_tmr  = 20'd1;
          end else begin
            phase_tmr = phase_tmr + 20'd1;
          end
        end else begin
          low_ticks = (mode == MODE_HOMING) ? cfg.home_low_ticks : cfg.run_low_ticks;
          if (phase_tmr >= low_ticks) begin
            pos       = dir ? pos + 24'sd1 : pos - 24'sd1;
            phase_tmr = '0;
            // Leaving home: the endstop must clear before the deadline step.
            if (mode == MODE_MOVING && armed) begin
              if (!active) begin
                armed = 1'b0;
              end else if (int'(pos) >= int'(deadline)) begin
                mode  = MODE_FAULT;
                armed = 1'b0;
              end
            end
            if (mode != MODE_FAULT) step_boundary(active);
          end else begin
            phase_tmr = phase_tmr + 20'd1;
          end
        end
      end
      e.step_out       = high_phase;
      e.dir_out        = dir;
      e.driver_disable = (mode == MODE_FAULT);
      e.busy_res       = (mode == MODE_HOMING || mode == MODE_MOVING);
      e.fault          = (mode == MODE_FAULT);
      e.position       = pos;
      expected_lines.push_back(e);
    endfunction

    function void report_field(string name, logic signed [24:0] e, logic signed [24:0] a);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (expected_lines.size() == 0) begin
        mismatches++;
        $display("%0t: result with no tick pending, actual %h", $time, got);
        return;
      end
      e = expected_lines.pop_front();
      checked++;
      if (got.step_out !== e.step_out)
        report_field("step_out", 25'(e.step_out), 25'(got.step_out));
      if (got.dir_out !== e.dir_out)
        report_field("dir_out", 25'(e.dir_out), 25'(got.dir_out));
      if (got.driver_disable !== e.driver_disable)
        report_field("driver_disable", 25'(e.driver_disable), 25'(got.driver_disable));
      if (got.busy_res !== e.busy_res)
        report_field("busy_res", 25'(e.busy_res), 25'(got.busy_res));
      if (got.fault !== e.fault)
        report_field("fault", 25'(e.fault), 25'(got.fault));
      if (got.position !== e.position)
        report_field("position", e.position, got.position);
    endfunction

    function int unsigned pending();
      return expected_lines.size();
    endfunction
  endclass

endpackage

### bench/tb_top.sv
// Testbench top for the stepper home-and-move controller.
// Drives directed and random ticks under several register settings and checks each result.
// Depends on shmc_pkg, shmc_tb_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_top;
  import shmc_pkg::*;
  import shmc_tb_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned PlanCount     = 7;
  localparam int unsigned PlanTicks     = 100;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  motion_scoreboard sb;
  int unsigned      sender_idle_pct   = 14;
  int unsigned      receiver_idle_pct = 82;
  int unsigned      stim_count        = 0;
  int unsigned      quiet_cycles      = 0;
  int unsigned      active_left       = 0;
  bit               cur_active        = 1'b0;
  cfg_t             plans[PlanCount];
  int unsigned      plan_delta[PlanCount];

  stepper_home_and_move_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1ns clk_i = ~clk_i;

  // Receiver side stalls at random.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  // Result checks and the watchdog on transfers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog expired with %0d results outstanding", sb.pending());
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // One tick transfer; the endstop is given as active and turned into a line level.
  task automatic drive_tick(logic [1:0] act, logic signed [23:0] tgt, bit active);
    in_t it;
    it.action          = act;
    it.target_position = tgt;
    it.endstop_level   = active ^ sb.cfg.endstop_invert;
    if (stim_count < 300) begin
      sender_idle_pct   = 14;
      receiver_idle_pct = 82;
    end else if (stim_count < 600) begin
      sender_idle_pct   = 82;
      receiver_idle_pct = 14;
    end else begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_tick(it);
    stim_count++;
  endtask

  // Hold off new ticks until every result has come back.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [19:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
  endtask

  task automatic load_settings(cfg_t c);
    cfg_write(CFG_PULSE_HIGH, 20'(c.pulse_high_ticks));
    cfg_write(CFG_HOME_LOW, c.home_low_ticks);
    cfg_write(CFG_RUN_LOW, c.run_low_ticks);
    cfg_write(CFG_CLEAR_WINDOW, 20'(c.clear_window_steps));
    cfg_write(CFG_ACTIVE_LOW, 20'(c.endstop_invert));
    cfg_write(CFG_HOME_FWD, 20'(c.home_forward));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Tick until the controller is idle: endstop made while homing, clear while moving.
  task automatic run_to_idle();
    while (sb.mode != MODE_IDLE) drive_tick(ActTick, 24'($urandom), sb.mode == MODE_HOMING);
  endtask

  // With very long low times only commands that finish at once are issued.
  function automatic bit slow_setting(cfg_t c);
    return c.home_low_ticks > 20'd64 || c.run_low_ticks > 20'd64;
  endfunction

  // Endstop held in runs; forced clear where leaving home would otherwise fault.
  function automatic bit next_endstop();
    if (active_left == 0) begin
      cur_active  = ($urandom_range(99) < 30);
      active_left = $urandom_range(1, 40);
    end
    active_left--;
    if (sb.mode == MODE_MOVING && sb.armed && int'(sb.pos) + 1 >= int'(sb.deadline))
      return 1'b0;
    return cur_active;
  endfunction

  task automatic run_plan(cfg_t plan, int unsigned max_delta);
    logic [1:0]         act;
    logic signed [23:0] tgt;
    bit                 active;
    bit                 slow;
    int unsigned        r;
    int                 delta;
    slow = slow_setting(plan);
    for (int n = 0; n < PlanTicks; n++) begin
      if ($urandom_range(59) == 0) drain_pipeline();
      active = next_endstop();
      tgt    = 24'($urandom);
      r      = $urandom_range(99);
      if (sb.mode == MODE_IDLE) begin
        if (r < 35) act = ActHome;
        else if (r < 80) act = ActMove;
        else if (r < 92) act = ActTick;
        else act = ActUnused;
        if (act == ActMove) begin
          delta = slow ? 0 : int'($urandom_range(2 * max_delta)) - int'(max_delta);
          tgt   = sb.pos + 24'(delta);
        end
        if (act == ActHome && slow && !active) act = ActTick;
      end else begin
        if (r < 80) act = ActTick;
        else if (r < 88) act = ActHome;
        else if (r < 96) act = ActMove;
        else act = ActUnused;
      end
      drive_tick(act, tgt, active);
    end
  endtask

  initial begin
    sb = new();
    plans[0] = '{8'd1, 20'd5, 20'd5, 16'd0, 1'b0, 1'b0};
    plans[1] = '{8'd2, 20'd7, 20'd5, 16'd65535, 1'b1, 1'b1};
    plans[2] = '{8'd1, 20'd1048575, 20'd1048575, 16'd1, 1'b1, 1'b1};
    plans[3] = '{8'd255, 20'd5, 20'd5, 16'd222, 1'b0, 1'b0};
    plans[4] = '{8'($urandom_range(1, 4)), 20'($urandom_range(5, 9)),
                 20'($urandom_range(5, 9)), 16'($urandom_range(0, 20)),
                 1'($urandom_range(1)), 1'($urandom_range(1))};
    plans[5] = '{8'($urandom_range(1, 4)), 20'($urandom_range(5, 9)),
                 20'($urandom_range(5, 9)), 16'($urandom),
                 1'($urandom_range(1)), 1'($urandom_range(1))};
    plans[6] = '{8'd1, 20'd5, 20'd6, 16'd3, 1'b0, 1'b1};
    plan_delta = '{12, 12, 12, 2, 12, 12, 12};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset-value registers: plain tick, unused code, move to the current position,
    // homing with the endstop already made.
    drive_tick(ActTick, 24'sd0, 1'b0);
    drive_tick(ActUnused, 24'sd5, 1'b1);
    drive_tick(ActMove, 24'sd0, 1'b0);
    drive_tick(ActHome, -24'sd1, 1'b1);
    drain_pipeline();
    load_settings('{8'd1, 20'd5, 20'd5, 16'd2, 1'b0, 1'b0});

    // Homing from clear endstop, with commands arriving while busy.
    drive_tick(ActHome, 24'sd0, 1'b0);
    drive_tick(ActMove, 24'sh800000, 1'b0);
    drive_tick(ActHome, 24'sh7fffff, 1'b0);
    drive_tick(ActUnused, -24'sd1, 1'b0);
    repeat (8) drive_tick(ActTick, 24'($urandom), 1'b0);
    run_to_idle();
    // Leaving home forward on the endstop, which then clears in time.
    drive_tick(ActMove, 24'sd2, 1'b1);
    run_to_idle();
    // Backward move, then a move to where the block already is.
    drive_tick(ActMove, -24'sd3, 1'b0);
    run_to_idle();
    drive_tick(ActMove, -24'sd3, 1'b0);

    // Random ticks under each register setting.
    for (int p = 0; p < PlanCount; p++) begin
      if (slow_setting(plans[p])) run_to_idle();
      drain_pipeline();
      load_settings(plans[p]);
      run_plan(plans[p], plan_delta[p]);
    end

    // Endstop never clears after leaving home: the fault latches for good.
    run_to_idle();
    drain_pipeline();
    load_settings('{8'd1, 20'd5, 20'd6, 16'd3, 1'b1, 1'b0});
    drive_tick(ActHome, 24'sd0, 1'b1);
    drive_tick(ActMove, 24'sh7fffff, 1'b1);
    while (sb.mode != MODE_FAULT) drive_tick(ActTick, 24'($urandom), 1'b1);
    drive_tick(ActHome, 24'($urandom), 1'b1);
    drive_tick(ActMove, 24'sd16, 1'b0);
    drive_tick(ActUnused, 24'($urandom), 1'b0);
    drive_tick(ActTick, 24'($urandom), 1'b1);

    drain_pipeline();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d ticks and %0d checked results over %0d register settings.",
             sb.ticks, sb.checked, PlanCount + 3);
    $display("Started %0d homing runs and %0d moves; fault latched: %0s.",
             sb.homes, sb.moves, (sb.mode == MODE_FAULT) ? "yes" : "no");
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/shmc_pkg.sv
src/shmc_step.sv
src/stepper_home_and_move_controller.sv
bench/shmc_tb_pkg.sv
bench/tb_top.sv
